[sv/ofifo_pkg.sv]
// ----------------------------------------------------------------------------
// ofifo_pkg
// Shared constants and types for the overwriting sample FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package ofifo_pkg;

  // port widths fixed by the interface
  localparam int unsigned PortDataW  = 64;
  localparam int unsigned CountW     = 7;
  localparam int unsigned KindW      = 2;

  // parameter defaults
  localparam int unsigned DefRingDepth   = 64;
  localparam int unsigned DefSampleWidth = 64;

  // largest number of samples a single pop may return
  localparam int unsigned MaxResults = 64;

  // request codes; the unused code behaves as a stats read
  localparam logic [KindW-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KindW-1:0] KIND_POP   = 2'd1;
  localparam logic [KindW-1:0] KIND_STATS = 2'd2;

  typedef enum logic {
    StIdle,
    StPop
  } state_e;

endpackage : ofifo_pkg

`default_nettype wire

[sv/ofifo_ram.sv]
// ----------------------------------------------------------------------------
// ofifo_ram
// Simple dual-port sample RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ofifo_ram #(
  parameter int unsigned Depth = ofifo_pkg::DefRingDepth,
  parameter int unsigned Width = ofifo_pkg::DefSampleWidth,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : ofifo_ram

`default_nettype wire

[sv/overwriting_sample_fifo_core.sv]
// ----------------------------------------------------------------------------
// overwriting_sample_fifo_core
// Circular sample FIFO that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
// Usage:
//  - A request word is taken on a rising edge with start_i high and busy_o
//    low. kind_i selects push, pop or stats read (the spare code reads stats).
//  - Push: sample goes into the RAM at the write slot. When the ring is
//    full the oldest entry is dropped, the read slot moves and the saturating
//    drop counter counts it. One result word, in the cycle after acceptance.
//    Pushes can be issued every cycle while busy_o is low.
//  - Pop: returns min(max_count_i, 64, occupancy) samples, oldest first, one
//    word per cycle starting in the cycle after acceptance (registered RAM
//    read). busy_o stays high while the rest of a pop's reads are issued, so
//    the single RAM read port sets the request rate, one read per sample.
//    An empty or zero-count pop returns one word with sample_valid_o low.
//  - Stats: one result word, in the cycle after acceptance.
//  - Every result word carries occupancy, peak and drop total as they stand
//    after the whole request. last_of_run_o marks the final word.
//  - Results are shown for exactly one cycle under strobe_o; the receiver
//    cannot stall. Reset clears slots, counters and the watermark; the RAM
//    is not cleared (entries are only read after being written).
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_sample_fifo_core #(
  parameter int unsigned RING_DEPTH   = ofifo_pkg::DefRingDepth,
  parameter int unsigned SAMPLE_WIDTH = ofifo_pkg::DefSampleWidth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // request side
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [ofifo_pkg::KindW-1:0]        kind_i,
  input  wire logic [ofifo_pkg::PortDataW-1:0]    sample_data_i,
  input  wire logic [ofifo_pkg::CountW-1:0]       max_count_i,
  // result side
  output logic                                    strobe_o,
  output logic      [ofifo_pkg::PortDataW-1:0]    popped_sample_o,
  output logic                                    sample_valid_o,
  output logic                                    last_of_run_o,
  output logic      [ofifo_pkg::CountW-1:0]       occupancy_o,
  output logic      [ofifo_pkg::CountW-1:0]       peak_occupancy_o,
  output logic      [ofifo_pkg::PortDataW-1:0]    dropped_total_o,
  output logic                                    overwrote_o
);

  localparam int unsigned PtrW   = $clog2(RING_DEPTH);
  localparam int unsigned CountW = ofifo_pkg::CountW;
  localparam int unsigned LossW  = ofifo_pkg::PortDataW;

  localparam logic [PtrW-1:0]   LastSlot = PtrW'(RING_DEPTH - 1);
  localparam logic [CountW-1:0] FullCnt  = CountW'(RING_DEPTH);
  localparam logic [CountW-1:0] MaxCnt   = CountW'(ofifo_pkg::MaxResults);

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] s);
    next_slot = (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  ofifo_pkg::state_e state_q, state_d;

  logic [PtrW-1:0]   wr_slot_q, wr_slot_d;
  logic [PtrW-1:0]   rd_slot_q, rd_slot_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] peak_q, peak_d;
  logic [LossW-1:0]  loss_q, loss_d;
  logic [CountW-1:0] remain_q, remain_d;   // reads still to issue in StPop

  // non-sample result word (push, stats, empty pop)
  logic res_stb_q, res_stb_d;
  logic res_ovw_q, res_ovw_d;

  // pop read pipeline: flags travel with the RAM's registered read
  logic rd_vld_q, rd_last_q, rd_last_d;

  // RAM control
  logic                    ram_we, ram_re;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  logic              accept;
  logic [CountW-1:0] want_sat, pop_n, cnt_inc;
  logic              full;

  assign accept   = start_i && !busy_o;
  assign full     = (count_q >= FullCnt);
  assign want_sat = (max_count_i > MaxCnt) ? MaxCnt : max_count_i;
  assign pop_n    = (want_sat < count_q) ? want_sat : count_q;
  assign cnt_inc  = count_q + 1'b1;

  // ---------------------------------------------------------------------------
  // Next state and control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    wr_slot_d = wr_slot_q;
    rd_slot_d = rd_slot_q;
    count_d   = count_q;
    peak_d    = peak_q;
    loss_d    = loss_q;
    remain_d  = remain_q;
    res_stb_d = 1'b0;
    res_ovw_d = 1'b0;
    rd_last_d = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    unique case (state_q)
      ofifo_pkg::StIdle: begin
        if (accept) begin
          case (kind_i)
            ofifo_pkg::KIND_PUSH: begin
              ram_we    = 1'b1;
              wr_slot_d = next_slot(wr_slot_q);
              res_stb_d = 1'b1;
              if (full) begin
                // drop oldest entry
                rd_slot_d = next_slot(rd_slot_q);
                loss_d    = (&loss_q) ? loss_q : loss_q + 1'b1;
                res_ovw_d = 1'b1;
              end else begin
                count_d = cnt_inc;
                if (cnt_inc > peak_q) begin
                  peak_d = cnt_inc;
                end
              end
            end
            ofifo_pkg::KIND_POP: begin
              if (pop_n == '0) begin
                res_stb_d = 1'b1;
              end else begin
                // first read goes out right away
                ram_re    = 1'b1;
                rd_slot_d = next_slot(rd_slot_q);
                count_d   = count_q - pop_n;
                rd_last_d = (pop_n == CountW'(1));
                remain_d  = pop_n - 1'b1;
                if (pop_n != CountW'(1)) begin
                  state_d = ofifo_pkg::StPop;
                end
              end
            end
            default: begin
              res_stb_d = 1'b1;
            end
          endcase
        end
      end
      ofifo_pkg::StPop: begin
        ram_re    = 1'b1;
        rd_slot_d = next_slot(rd_slot_q);
        remain_d  = remain_q - 1'b1;
        rd_last_d = (remain_q == CountW'(1));
        if (remain_q == CountW'(1)) begin
          state_d = ofifo_pkg::StIdle;
        end
      end
      default: begin
        state_d = ofifo_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ofifo_pkg::StIdle;
      wr_slot_q <= '0;
      rd_slot_q <= '0;
      count_q   <= '0;
      peak_q    <= '0;
      loss_q    <= '0;
      remain_q  <= '0;
      res_stb_q <= 1'b0;
      res_ovw_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_slot_q <= wr_slot_d;
      rd_slot_q <= rd_slot_d;
      count_q   <= count_d;
      peak_q    <= peak_d;
      loss_q    <= loss_d;
      remain_q  <= remain_d;
      res_stb_q <= res_stb_d;
      res_ovw_q <= res_ovw_d;
      rd_vld_q  <= ram_re;
      rd_last_q <= rd_last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample RAM. Writes only happen while idle and reads only when a pop is taken
  // or in StPop, so busy_o is the interlock: a read never meets a write to the same slot.
  // ---------------------------------------------------------------------------
  ofifo_ram #(
    .Depth (RING_DEPTH),
    .Width (SAMPLE_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_slot_q),
    .wdata_i (sample_data_i[SAMPLE_WIDTH-1:0]),
    .re_i    (ram_re),
    .raddr_i (rd_slot_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result port. Counters already hold post-request values when a word shows.
  // ---------------------------------------------------------------------------
  assign busy_o           = (state_q == ofifo_pkg::StPop);
  assign strobe_o         = res_stb_q || rd_vld_q;
  assign popped_sample_o  = rd_vld_q ? ofifo_pkg::PortDataW'(ram_rdata) : '0;
  assign sample_valid_o   = rd_vld_q;
  assign last_of_run_o    = res_stb_q || (rd_vld_q && rd_last_q);
  assign occupancy_o      = count_q;
  assign peak_occupancy_o = peak_q;
  assign dropped_total_o  = loss_q;
  assign overwrote_o      = res_stb_q && res_ovw_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_stb_q && rd_vld_q))
    else $error("pop word and status word collide");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("occupancy above ring depth");

  a_peak_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= count_q)
    else $error("watermark below occupancy");

  a_push_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == ofifo_pkg::KIND_PUSH) |=>
      (strobe_o && !sample_valid_o && last_of_run_o))
    else $error("push gave no result word");

  a_pop_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (rd_vld_q && sample_valid_o))
    else $error("pop cycle issued no read");

endmodule : overwriting_sample_fifo_core

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for overwriting_sample_fifo_core. Requests are sent in
// bursts with random gaps. Each accepted request is run through a behavioral
// ring model that queues the result words it should cause. Every strobed
// result word is compared field by field against the oldest queued word.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned RingDepth   = ofifo_pkg::DefRingDepth;
  localparam int unsigned SampleW     = ofifo_pkg::DefSampleWidth;
  localparam int unsigned DataW       = ofifo_pkg::PortDataW;
  localparam int unsigned CntW        = ofifo_pkg::CountW;
  localparam int unsigned KndW        = ofifo_pkg::KindW;
  localparam int unsigned MaxRes      = ofifo_pkg::MaxResults;
  localparam int unsigned RandomWords = 390;
  localparam int unsigned LimitCycles = 200000;

  // the spare request code, which the core treats as a stats read
  localparam logic [KndW-1:0] KIND_SPARE = 2'd3;

  // one result word as seen on the result ports
  typedef struct {
    logic [DataW-1:0] sample;
    logic             valid;
    logic             last;
    logic [CntW-1:0]  occ;
    logic [CntW-1:0]  peak;
    logic [DataW-1:0] drops;
    logic             ovw;
  } fifo_word_t;

  // Ring model plus the queue of result words it predicts.
  class fifo_scoreboard;
    logic [DataW-1:0] ring [RingDepth];
    int unsigned      wr_slot;
    int unsigned      rd_slot;
    int unsigned      fill;
    int unsigned      peak;
    logic [DataW-1:0] drops;
    fifo_word_t       pending_q [$];
    int unsigned      errors;

    function new();
      wr_slot = 0;
      rd_slot = 0;
      fill    = 0;
      peak    = 0;
      drops   = '0;
      errors  = 0;
    endfunction

    // queue a word; counters are taken as they stand after the whole request
    function void queue_word(logic [DataW-1:0] smp, logic vld, logic lst,
                             logic ovw);
      fifo_word_t w;
      w.sample = smp;
      w.valid  = vld;
      w.last   = lst;
      w.occ    = CntW'(fill);
      w.peak   = CntW'(peak);
      w.drops  = drops;
      w.ovw    = ovw;
      pending_q.push_back(w);
    endfunction

    function void note_request(logic [KndW-1:0] kind, logic [DataW-1:0] data,
                               logic [CntW-1:0] cnt);
      logic [DataW-1:0] mask;
      logic [DataW-1:0] taken [$];
      int unsigned      want;
      logic             ovw;
      mask = ~64'd0 >> (64 - SampleW);
      case (kind)
        ofifo_pkg::KIND_PUSH: begin
          ovw = 1'b0;
          if (fill >= RingDepth) begin
            // full: oldest entry is lost, loss count saturates
            rd_slot = (rd_slot + 1) % RingDepth;
            if (drops != ~64'd0) drops = drops + 1;
            ovw = 1'b1;
          end else begin
            fill++;
          end
          ring[wr_slot] = data & mask;
          wr_slot = (wr_slot + 1) % RingDepth;
          if (fill > peak) peak = fill;
          queue_word('0, 1'b0, 1'b1, ovw);
        end
        ofifo_pkg::KIND_POP: begin
          want = (cnt > MaxRes) ? MaxRes : cnt;
          while (taken.size() < want && fill != 0) begin
            taken.push_back(ring[rd_slot]);
            rd_slot = (rd_slot + 1) % RingDepth;
            fill--;
          end
          if (taken.size() == 0) begin
            queue_word('0, 1'b0, 1'b1, 1'b0);
          end else begin
            foreach (taken[i]) queue_word(taken[i], 1'b1, i == taken.size() - 1, 1'b0);
          end
        end
        default: begin
          // stats read and the spare code: no state change
          queue_word('0, 1'b0, 1'b1, 1'b0);
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [DataW-1:0] exp_v,
                            logic [DataW-1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(fifo_word_t got);
      fifo_word_t exp_w;
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      cmp_field("popped_sample", exp_w.sample, got.sample);
      cmp_field("sample_valid", exp_w.valid, got.valid);
      cmp_field("last_of_run", exp_w.last, got.last);
      cmp_field("occupancy", exp_w.occ, got.occ);
      cmp_field("peak_occupancy", exp_w.peak, got.peak);
      cmp_field("dropped_total", exp_w.drops, got.drops);
      cmp_field("overwrote", exp_w.ovw, got.ovw);
    endfunction
  endclass

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             start_i       = 1'b0;
  logic [KndW-1:0]  kind_i        = ofifo_pkg::KIND_STATS;
  logic [DataW-1:0] sample_data_i = '0;
  logic [CntW-1:0]  max_count_i   = '0;
  logic             busy_o;
  logic             strobe_o;
  logic [DataW-1:0] popped_sample_o;
  logic             sample_valid_o;
  logic             last_of_run_o;
  logic [CntW-1:0]  occupancy_o;
  logic [CntW-1:0]  peak_occupancy_o;
  logic [DataW-1:0] dropped_total_o;
  logic             overwrote_o;

  fifo_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    burst_left = 0;

  overwriting_sample_fifo_core #(
    .RING_DEPTH  (RingDepth),
    .SAMPLE_WIDTH(SampleW)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .sample_data_i   (sample_data_i),
    .max_count_i     (max_count_i),
    .strobe_o        (strobe_o),
    .popped_sample_o (popped_sample_o),
    .sample_valid_o  (sample_valid_o),
    .last_of_run_o   (last_of_run_o),
    .occupancy_o     (occupancy_o),
    .peak_occupancy_o(peak_occupancy_o),
    .dropped_total_o (dropped_total_o),
    .overwrote_o     (overwrote_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Monitor. All DUT outputs and TB drives change by NBA at the edge, so the
  // values read here are the ones that stood during the cycle just ended.
  always @(posedge clk_i) begin
    fifo_word_t got;
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_request(kind_i, sample_data_i, max_count_i);
      if (strobe_o) begin
        got.sample = popped_sample_o;
        got.valid  = sample_valid_o;
        got.last   = last_of_run_o;
        got.occ    = occupancy_o;
        got.peak   = peak_occupancy_o;
        got.drops  = dropped_total_o;
        got.ovw    = overwrote_o;
        sb.check_word(got);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LimitCycles) begin
      $display("overwriting_sample_fifo_core: mismatch");
      $finish;
    end
  end

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // pop sizes: mostly short runs, with zero, the full 64 and oversized mixed in
  function automatic logic [CntW-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return CntW'(MaxRes);
      2:       return CntW'($urandom_range(65, 127));
      3:       return CntW'($urandom_range(9, 40));
      default: return CntW'($urandom_range(1, 8));
    endcase
  endfunction

  // Send one request word; returns once it is taken (and after any gap). Start
  // stays high into the next word unless the burst ends and a gap is inserted.
  task automatic send_word(input logic [KndW-1:0] kind, input logic [DataW-1:0] data,
                           input logic [CntW-1:0] cnt);
    int unsigned gap;
    start_i       <= 1'b1;
    kind_i        <= kind;
    sample_data_i <= data;
    max_count_i   <= cnt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int unsigned     phase_left;
    int unsigned     mode;
    int unsigned     roll;
    logic [KndW-1:0] stats_kind;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty reads, payload extremes, zero/oversized counts, spare code
    send_word(ofifo_pkg::KIND_STATS, rand64(), pick_count());
    send_word(ofifo_pkg::KIND_POP, '0, 7'd5);            // pop on empty ring
    send_word(ofifo_pkg::KIND_PUSH, '0, '0);
    send_word(ofifo_pkg::KIND_PUSH, ~64'd0, 7'd127);
    send_word(ofifo_pkg::KIND_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    send_word(ofifo_pkg::KIND_PUSH, 64'h5555_5555_5555_5555, '0);
    send_word(ofifo_pkg::KIND_POP, rand64(), '0);        // zero count, ring not empty
    send_word(ofifo_pkg::KIND_POP, '0, 7'd1);
    send_word(ofifo_pkg::KIND_POP, '0, 7'd127);          // oversized, drains the rest
    send_word(KIND_SPARE, ~64'd0, 7'd127);
    repeat (4) send_word(ofifo_pkg::KIND_PUSH, rand64(), pick_count());
    send_word(ofifo_pkg::KIND_POP, '0, 7'(MaxRes));      // asks for more than held
    send_word(ofifo_pkg::KIND_POP, '0, 7'(MaxRes));      // empty again
    send_word(ofifo_pkg::KIND_PUSH, rand64(), '0);
    send_word(ofifo_pkg::KIND_STATS, ~64'd0, 7'd127);
    send_word(ofifo_pkg::KIND_POP, rand64(), 7'd2);

    // Random phases. Fill phases push the ring past full so the overwrite,
    // wrap and watermark paths get exercised; drain phases empty it again.
    // The first phase is a long fill to reach overflow early.
    mode       = 0;
    phase_left = 100;
    repeat (RandomWords) begin
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 90);
      end
      phase_left--;
      roll       = $urandom_range(0, 99);
      stats_kind = $urandom_range(0, 1) ? ofifo_pkg::KIND_STATS : KIND_SPARE;
      case (mode)
        0, 1: begin
          if (roll < 85) send_word(ofifo_pkg::KIND_PUSH, rand64(), pick_count());
          else if (roll < 95) send_word(ofifo_pkg::KIND_POP, rand64(), pick_count());
          else send_word(stats_kind, rand64(), pick_count());
        end
        2: begin
          if (roll < 25) send_word(ofifo_pkg::KIND_PUSH, rand64(), pick_count());
          else if (roll < 90) send_word(ofifo_pkg::KIND_POP, rand64(), pick_count());
          else send_word(stats_kind, rand64(), pick_count());
        end
        default: begin
          if (roll < 50) send_word(ofifo_pkg::KIND_PUSH, rand64(), pick_count());
          else if (roll < 90) send_word(ofifo_pkg::KIND_POP, rand64(), pick_count());
          else send_word(stats_kind, rand64(), pick_count());
        end
      endcase
    end
    start_i <= 1'b0;

    // drain: wait for every predicted word, then keep watching for stray words
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("overwriting_sample_fifo_core: match");
    end else begin
      $display("overwriting_sample_fifo_core: mismatch");
    end
    $finish;
  end

endmodule
